// ----- hw/rtl/csphr_pkg.sv -----
// csphr_pkg: widths, constants, register codes and sideband types of the
// checkered sphere texel pipeline
// no dependencies
package csphr_pkg;

  localparam int R_W      = 8;
  localparam int COL_W    = 9;
  localparam int COEF_W   = 16;
  localparam int XY_W     = 11;
  localparam int X1_W     = 26;
  localparam int Z_W      = 14;
  localparam int RAD_W    = 28;
  localparam int REM_W    = 15;
  localparam int X2_W     = 42;
  localparam int PR_W     = 41;
  localparam int PT_W     = 60;
  localparam int NUM_W    = 15;
  localparam int Q_W      = 8;
  localparam int L_W      = 9;
  localparam int PADDR_W  = 5;
  localparam int BAND_N   = 8;

  localparam logic [18:0] TAN_EIGHTH_Q20 = 19'd434334;
  localparam logic [7:0]  RED_LEVEL      = 8'd216;
  localparam logic [7:0]  FULL_LEVEL     = 8'd255;
  localparam logic [8:0]  LIGHT_BASE     = 9'd128;

  // negated band cosines, q16
  localparam logic signed [17:0] NEG_BAND_Q16 [0:BAND_N-1] = '{
    -18'sd60547, -18'sd46341, -18'sd25080, 18'sd0,
    18'sd25080, 18'sd46341, 18'sd60547, 18'sd65536
  };

  typedef enum logic [2:0] {
    REG_RADIUS    = 3'd0,
    REG_TILT_COS  = 3'd1,
    REG_TILT_SIN  = 3'd2,
    REG_SPIN_COS  = 3'd3,
    REG_SPIN_SIN  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                   hit;
    logic signed [X1_W-1:0] x1;
    logic signed [X1_W-1:0] y1;
  } sq_side_t;

  typedef struct packed {
    logic hit;
    logic parity;
  } div_side_t;

endpackage

// ----- hw/rtl/checkered_sphere_rasterizer_top.sv -----
// checkered_sphere_rasterizer_top: texel pipeline of a lit checkered sphere
// one item every cycle, busy stays low; most of the depth is in the 14 stage
// square root and 8 stage divider; synchronous active-low reset clears the
// pipeline valids and loads the register defaults; depends on csphr_pkg,
// csphr_sqrt, csphr_div
module checkered_sphere_rasterizer_top #(
  parameter int MAX_RADIUS = 255
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [csphr_pkg::COL_W-1:0]          in_column,
  input  logic [csphr_pkg::COL_W-1:0]          in_row,
  output logic                                 out_valid,
  output logic [7:0]                           out_alpha,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [csphr_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  // configuration registers
  logic [csphr_pkg::R_W-1:0]           radius_r;
  logic signed [csphr_pkg::COEF_W-1:0] tilt_cos_r;
  logic signed [csphr_pkg::COEF_W-1:0] tilt_sin_r;
  logic signed [csphr_pkg::COEF_W-1:0] spin_cos_r;
  logic signed [csphr_pkg::COEF_W-1:0] spin_sin_r;
  csphr_pkg::reg_idx_t                 reg_sel;
  logic                                cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = csphr_pkg::reg_idx_t'(paddr[csphr_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 8'd120;
      tilt_cos_r <= 16'sd15833;
      tilt_sin_r <= -16'sd4212;
      spin_cos_r <= 16'sd16384;
      spin_sin_r <= 16'sd0;
    end else if (cfg_wr) begin
      case (reg_sel)
        csphr_pkg::REG_RADIUS:   radius_r   <= pwdata[7:0];
        csphr_pkg::REG_TILT_COS: tilt_cos_r <= pwdata[15:0];
        csphr_pkg::REG_TILT_SIN: tilt_sin_r <= pwdata[15:0];
        csphr_pkg::REG_SPIN_COS: spin_cos_r <= pwdata[15:0];
        csphr_pkg::REG_SPIN_SIN: spin_sin_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      csphr_pkg::REG_RADIUS:   prdata = {24'd0, radius_r};
      csphr_pkg::REG_TILT_COS: prdata = {16'd0, tilt_cos_r};
      csphr_pkg::REG_TILT_SIN: prdata = {16'd0, tilt_sin_r};
      csphr_pkg::REG_SPIN_COS: prdata = {16'd0, spin_cos_r};
      csphr_pkg::REG_SPIN_SIN: prdata = {16'd0, spin_sin_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // effective radius
  logic [csphr_pkg::R_W-1:0] r_eff;
  assign r_eff = ({2'b00, radius_r} > 10'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : radius_r;

  // stage 1: centre the coordinates
  logic                               s1_v_r;
  logic                               s1_out_r;
  logic signed [csphr_pkg::XY_W-1:0]  s1_x_r;
  logic signed [csphr_pkg::XY_W-1:0]  s1_y_r;
  logic [csphr_pkg::COL_W-1:0]        two_r;

  assign two_r = {r_eff, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
    s1_out_r <= (r_eff == '0) || (in_column >= two_r) || (in_row >= two_r);
    s1_x_r   <= $signed({2'b00, in_column} - {3'b000, r_eff});
    s1_y_r   <= $signed({2'b00, in_row} - {3'b000, r_eff});
  end

  // stage 2: squares and tilt products
  logic               s2_v_r;
  logic               s2_out_r;
  logic signed [21:0] s2_xx_r;
  logic signed [21:0] s2_yy_r;
  logic [15:0]        s2_rr_r;
  logic signed [26:0] s2_xtc_r;
  logic signed [26:0] s2_yts_r;
  logic signed [26:0] s2_xts_r;
  logic signed [26:0] s2_ytc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_out_r <= s1_out_r;
    s2_xx_r  <= 22'(s1_x_r * s1_x_r);
    s2_yy_r  <= 22'(s1_y_r * s1_y_r);
    s2_rr_r  <= 16'(r_eff * r_eff);
    s2_xtc_r <= 27'(s1_x_r * tilt_cos_r);
    s2_yts_r <= 27'(s1_y_r * tilt_sin_r);
    s2_xts_r <= 27'(s1_x_r * tilt_sin_r);
    s2_ytc_r <= 27'(s1_y_r * tilt_cos_r);
  end

  // stage 3: depth radicand and tilted point
  logic signed [22:0]              d_val;
  logic                            s3_v_r;
  logic [csphr_pkg::RAD_W-1:0]     s3_rad_r;
  csphr_pkg::sq_side_t             s3_side_r;
  csphr_pkg::sq_side_t             s3_side_nxt;

  always_comb begin
    d_val = $signed({7'd0, s2_rr_r}) - 23'(s2_xx_r) - 23'(s2_yy_r);
    s3_side_nxt.hit = !s2_out_r && !d_val[22];
    s3_side_nxt.x1  = csphr_pkg::X1_W'(s2_xtc_r - s2_yts_r);
    s3_side_nxt.y1  = csphr_pkg::X1_W'(s2_xts_r + s2_ytc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_rad_r  <= s3_side_nxt.hit ? {d_val[15:0], 12'd0} : '0;
    s3_side_r <= s3_side_nxt;
  end

  logic                        sq_v;
  logic [csphr_pkg::Z_W-1:0]   sq_root;
  csphr_pkg::sq_side_t         sq_side;

  csphr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_rad    (s3_rad_r),
    .in_side   (s3_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: spin products and latitude band parity
  logic                        s4_v_r;
  logic                        s4_in_r;
  logic                        s4_band_r;
  logic [csphr_pkg::Z_W-1:0]   s4_z_r;
  logic signed [41:0]          s4_x1sc_r;
  logic signed [41:0]          s4_x1ss_r;
  logic signed [30:0]          s4_zss_r;
  logic signed [30:0]          s4_zsc_r;
  logic                        band_par;
  logic signed [27:0]          band_lhs;
  logic signed [27:0]          band_rhs;

  always_comb begin
    band_par = 1'b0;
    band_lhs = {sq_side.y1, 2'b00};
    band_rhs = '0;
    for (int k = 0; k < csphr_pkg::BAND_N; k++) begin
      band_rhs = 28'(csphr_pkg::NEG_BAND_Q16[k] * $signed({1'b0, r_eff}));
      band_par = band_par ^ (band_lhs >= band_rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= sq_v;
    end
    s4_in_r   <= sq_side.hit;
    s4_band_r <= band_par;
    s4_z_r    <= sq_root;
    s4_x1sc_r <= 42'(sq_side.x1 * spin_cos_r);
    s4_x1ss_r <= 42'(sq_side.x1 * spin_sin_r);
    s4_zss_r  <= 31'($signed({1'b0, sq_root}) * spin_sin_r);
    s4_zsc_r  <= 31'($signed({1'b0, sq_root}) * spin_cos_r);
  end

  // stage 5: spun point
  logic                                s5_v_r;
  logic                                s5_in_r;
  logic                                s5_band_r;
  logic [csphr_pkg::Z_W-1:0]           s5_z_r;
  logic signed [csphr_pkg::X2_W-1:0]   s5_x2_r;
  logic signed [csphr_pkg::X2_W-1:0]   s5_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_in_r   <= s4_in_r;
    s5_band_r <= s4_band_r;
    s5_z_r    <= s4_z_r;
    s5_x2_r   <= s4_x1sc_r - (42'(s4_zss_r) <<< 8);
    s5_d2_r   <= s4_x1ss_r + (42'(s4_zsc_r) <<< 8);
  end

  // stage 6: fold into a quadrant
  logic signed [csphr_pkg::X2_W-1:0]   ca;
  logic signed [csphr_pkg::X2_W-1:0]   cb;
  logic signed [csphr_pkg::X2_W-1:0]   p_val;
  logic signed [csphr_pkg::X2_W-1:0]   r_val;
  logic                                s6_v_r;
  logic                                s6_in_r;
  logic                                s6_band_r;
  logic                                s6_zero_r;
  logic [csphr_pkg::Z_W-1:0]           s6_z_r;
  logic [csphr_pkg::PR_W-1:0]          s6_p_r;
  logic [csphr_pkg::PR_W-1:0]          s6_q_r;

  always_comb begin
    ca = -s5_x2_r;
    cb = -s5_d2_r;
    if (cb > 0 && ca >= 0) begin
      p_val = cb;
      r_val = ca;
    end else if (ca > 0 && cb <= 0) begin
      p_val = ca;
      r_val = -cb;
    end else if (cb < 0 && ca <= 0) begin
      p_val = -cb;
      r_val = -ca;
    end else begin
      p_val = -ca;
      r_val = cb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_in_r   <= s5_in_r;
    s6_band_r <= s5_band_r;
    s6_zero_r <= (ca == '0) && (cb == '0);
    s6_z_r    <= s5_z_r;
    s6_p_r    <= p_val[csphr_pkg::PR_W-1:0];
    s6_q_r    <= r_val[csphr_pkg::PR_W-1:0];
  end

  // stage 7: scale by tan of an eighth of pi
  logic                                s7_v_r;
  logic                                s7_in_r;
  logic                                s7_band_r;
  logic                                s7_zero_r;
  logic [csphr_pkg::Z_W-1:0]           s7_z_r;
  logic [csphr_pkg::PR_W-1:0]          s7_p_r;
  logic [csphr_pkg::PR_W-1:0]          s7_q_r;
  logic [csphr_pkg::PT_W-1:0]          s7_pt_r;
  logic [csphr_pkg::PT_W-1:0]          s7_qt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= s6_v_r;
    end
    s7_in_r   <= s6_in_r;
    s7_band_r <= s6_band_r;
    s7_zero_r <= s6_zero_r;
    s7_z_r    <= s6_z_r;
    s7_p_r    <= s6_p_r;
    s7_q_r    <= s6_q_r;
    s7_pt_r   <= csphr_pkg::PT_W'(s6_p_r * csphr_pkg::TAN_EIGHTH_Q20);
    s7_qt_r   <= csphr_pkg::PT_W'(s6_q_r * csphr_pkg::TAN_EIGHTH_Q20);
  end

  // stage 8: sector parity and checker colour
  logic                           c_lo;
  logic                           c_mid;
  logic                           c_hi;
  logic                           s8_v_r;
  logic [csphr_pkg::NUM_W-1:0]    s8_num_r;
  csphr_pkg::div_side_t           s8_side_r;

  assign c_lo  = {s7_q_r, 20'd0} >= {1'b0, s7_pt_r};
  assign c_mid = s7_q_r >= s7_p_r;
  assign c_hi  = {1'b0, s7_qt_r} >= {s7_p_r, 20'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else begin
      s8_v_r <= s7_v_r;
    end
    s8_num_r         <= {s7_z_r, 1'b0};
    s8_side_r.hit    <= s7_in_r;
    s8_side_r.parity <= s7_band_r ^ (!s7_zero_r && (c_lo ^ c_mid ^ c_hi));
  end

  logic                        dv_v;
  logic [csphr_pkg::Q_W-1:0]   dv_quot;
  csphr_pkg::div_side_t        dv_side;

  csphr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s8_v_r),
    .in_num    (s8_num_r),
    .in_den    (r_eff),
    .in_side   (s8_side_r),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // output stage: lighting
  logic [csphr_pkg::L_W-1:0]  light;
  logic [16:0]                prod_red;
  logic [16:0]                prod_full;
  logic                       out_valid_r;
  logic [7:0]                 out_alpha_r;
  logic [7:0]                 out_red_r;
  logic [7:0]                 out_green_r;
  logic [7:0]                 out_blue_r;

  assign light     = csphr_pkg::LIGHT_BASE + {1'b0, dv_quot};
  assign prod_red  = 17'(csphr_pkg::RED_LEVEL) * 17'(light);
  assign prod_full = 17'(csphr_pkg::FULL_LEVEL) * 17'(light);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
    if (!dv_side.hit) begin
      out_alpha_r <= 8'd0;
      out_red_r   <= 8'd0;
      out_green_r <= 8'd0;
      out_blue_r  <= 8'd0;
    end else if (!dv_side.parity) begin
      out_alpha_r <= csphr_pkg::FULL_LEVEL;
      out_red_r   <= prod_red[15:8];
      out_green_r <= 8'd0;
      out_blue_r  <= 8'd0;
    end else begin
      out_alpha_r <= csphr_pkg::FULL_LEVEL;
      out_red_r   <= prod_full[15:8];
      out_green_r <= prod_full[15:8];
      out_blue_r  <= prod_full[15:8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // checks
  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == 8'd0 || out_alpha == 8'd255))
    else $error("alpha neither transparent nor opaque");

  a_clear_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha == 8'd0 |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("transparent texel carries colour");

  a_checker_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha != 8'd0 |->
      out_green == out_blue && (out_green == 8'd0 || out_green == out_red))
    else $error("lit texel neither red nor white");

  a_lit_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha != 8'd0 |-> out_red >= 8'd108)
    else $error("lit red channel below half brightness");

endmodule

// ----- hw/rtl/csphr_sqrt.sv -----
// csphr_sqrt: pipelined integer square root, one result bit per stage
// depends on csphr_pkg
module csphr_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [csphr_pkg::RAD_W-1:0]       in_rad,
  input  csphr_pkg::sq_side_t               in_side,
  output logic                              out_valid,
  output logic [csphr_pkg::Z_W-1:0]         out_root,
  output csphr_pkg::sq_side_t               out_side
);

  localparam int NS = csphr_pkg::Z_W;

  logic                              valid_r [1:NS];
  logic [csphr_pkg::REM_W-1:0]       rem_r   [1:NS];
  logic [csphr_pkg::Z_W-1:0]         root_r  [1:NS];
  logic [csphr_pkg::RAD_W-1:0]       rad_r   [1:NS];
  csphr_pkg::sq_side_t               side_r  [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                          v_p;
    logic [csphr_pkg::REM_W-1:0]   rem_p;
    logic [csphr_pkg::Z_W-1:0]     root_p;
    logic [csphr_pkg::RAD_W-1:0]   rad_p;
    csphr_pkg::sq_side_t           side_p;
    logic [csphr_pkg::REM_W+1:0]   rem_t;
    logic [csphr_pkg::REM_W+1:0]   trial;
    logic [csphr_pkg::REM_W-1:0]   rem_nxt;
    logic [csphr_pkg::Z_W-1:0]     root_nxt;

    if (s == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = valid_r[s];
      assign rem_p  = rem_r[s];
      assign root_p = root_r[s];
      assign rad_p  = rad_r[s];
      assign side_p = side_r[s];
    end

    always_comb begin
      rem_t = {rem_p, rad_p[csphr_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_p, 2'b01};
      if (rem_t >= trial) begin
        rem_nxt  = csphr_pkg::REM_W'(rem_t - trial);
        root_nxt = {root_p[csphr_pkg::Z_W-2:0], 1'b1};
      end else begin
        rem_nxt  = csphr_pkg::REM_W'(rem_t);
        root_nxt = {root_p[csphr_pkg::Z_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= v_p;
      end
      rem_r[s+1]  <= rem_nxt;
      root_r[s+1] <= root_nxt;
      rad_r[s+1]  <= {rad_p[csphr_pkg::RAD_W-3:0], 2'b00};
      side_r[s+1] <= side_p;
    end
  end

  assign out_valid = valid_r[NS];
  assign out_root  = root_r[NS];
  assign out_side  = side_r[NS];

endmodule

// ----- hw/rtl/csphr_div.sv -----
// csphr_div: pipelined restoring divider, one quotient bit per stage
// depends on csphr_pkg
module csphr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [csphr_pkg::NUM_W-1:0]       in_num,
  input  logic [csphr_pkg::R_W-1:0]         in_den,
  input  csphr_pkg::div_side_t              in_side,
  output logic                              out_valid,
  output logic [csphr_pkg::Q_W-1:0]         out_quot,
  output csphr_pkg::div_side_t              out_side
);

  localparam int NS = csphr_pkg::Q_W;

  logic                              valid_r [1:NS];
  logic [csphr_pkg::NUM_W-1:0]       rem_r   [1:NS];
  logic [csphr_pkg::Q_W-1:0]         quot_r  [1:NS];
  csphr_pkg::div_side_t              side_r  [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                          v_p;
    logic [csphr_pkg::NUM_W-1:0]   rem_p;
    logic [csphr_pkg::Q_W-1:0]     quot_p;
    csphr_pkg::div_side_t          side_p;
    logic [csphr_pkg::NUM_W:0]     sub;
    logic                          take;

    if (s == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = in_num;
      assign quot_p = '0;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = valid_r[s];
      assign rem_p  = rem_r[s];
      assign quot_p = quot_r[s];
      assign side_p = side_r[s];
    end

    assign sub  = (csphr_pkg::NUM_W+1)'(in_den) << (NS - 1 - s);
    assign take = {1'b0, rem_p} >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= v_p;
      end
      rem_r[s+1]  <= take ? csphr_pkg::NUM_W'({1'b0, rem_p} - sub) : rem_p;
      quot_r[s+1] <= {quot_p[csphr_pkg::Q_W-2:0], take};
      side_r[s+1] <= side_p;
    end
  end

  assign out_valid = valid_r[NS];
  assign out_quot  = quot_r[NS];
  assign out_side  = side_r[NS];

endmodule

// ----- tb/checkered_sphere_rasterizer_top_tb.sv -----
// checkered_sphere_rasterizer_top_tb: drives texel coordinates under several sphere
// settings and checks every argb texel against a fixed-point texel predictor or
// a given expected texel; depends on csphr_pkg and checkered_sphere_rasterizer_top
module checkered_sphere_rasterizer_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RADIUS_BOUND = 255;
  localparam longint TAN_Q20 = 434334;
  localparam longint BAND_COS_Q16 [0:7] = '{60547, 46341, 25080, 0,
                                            -25080, -46341, -60547, -65536};

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_t;

  typedef struct {
    logic [8:0] col;
    logic [8:0] row;
    bit         typed;
    texel_t     texel;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [csphr_pkg::COL_W-1:0] in_column = '0;
  logic [csphr_pkg::COL_W-1:0] in_row = '0;
  logic out_valid;
  logic [7:0] out_alpha, out_red, out_green, out_blue;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [csphr_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [7:0] radius_q = 8'd120;
  logic signed [15:0] tilt_cos_q = 16'sd15833;
  logic signed [15:0] tilt_sin_q = -16'sd4212;
  logic signed [15:0] spin_cos_q = 16'sd16384;
  logic signed [15:0] spin_sin_q = 16'sd0;

  texel_t texels_due[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  checkered_sphere_rasterizer_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_alpha(out_alpha), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint int_sqrt(input longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 30;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int sector_of(input longint a, input longint b);
    longint ca, cb, p, r;
    int q, sub;
    ca = -a;
    cb = -b;
    if (ca == 0 && cb == 0) return 8;
    if (cb > 0 && ca >= 0) begin
      q = 0; p = cb; r = ca;
    end else if (ca > 0 && cb <= 0) begin
      q = 1; p = ca; r = -cb;
    end else if (cb < 0 && ca <= 0) begin
      q = 2; p = -cb; r = -ca;
    end else begin
      q = 3; p = -ca; r = cb;
    end
    sub = 0;
    if (r * 1048576 >= p * TAN_Q20) sub++;
    if (r >= p) sub++;
    if (r * TAN_Q20 >= p * 1048576) sub++;
    return q * 4 + sub;
  endfunction

  function automatic texel_t shade_texel(input logic [8:0] col, input logic [8:0] row);
    texel_t t;
    longint rad, x, y, d, z6, x1, y1, x2, d2, light, base_r, base_gb;
    int band;
    t = '0;
    rad = radius_q;
    if (rad > RADIUS_BOUND) rad = RADIUS_BOUND;
    if (rad == 0 || col >= 2 * rad || row >= 2 * rad) return t;
    x = longint'(col) - rad;
    y = longint'(row) - rad;
    d = rad * rad - x * x - y * y;
    if (d < 0) return t;
    z6 = int_sqrt(d * 4096);
    x1 = x * tilt_cos_q - y * tilt_sin_q;
    y1 = x * tilt_sin_q + y * tilt_cos_q;
    x2 = x1 * spin_cos_q - z6 * 256 * spin_sin_q;
    d2 = x1 * spin_sin_q + z6 * 256 * spin_cos_q;
    band = 0;
    for (int k = 0; k < 8; k++)
      if (y1 * 4 >= -BAND_COS_Q16[k] * rad) band++;
    light = ((rad * 64 + z6) * 2) / rad;
    if (((sector_of(x2, d2) + band) & 1) == 0) begin
      base_r = csphr_pkg::RED_LEVEL; base_gb = 0;
    end else begin
      base_r = 255; base_gb = 255;
    end
    t.alpha = csphr_pkg::FULL_LEVEL;
    t.red = 8'((base_r * light) >> 8);
    t.green = 8'((base_gb * light) >> 8);
    t.blue = t.green;
    return t;
  endfunction

  always @(negedge clk) begin
    texel_t got, want;
    if (rst_n && out_valid) begin
      got = {out_alpha, out_red, out_green, out_blue};
      if (texels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected texel %h", got);
      end else begin
        want = texels_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("texel mismatch: expected a%0d r%0d g%0d b%0d, got a%0d r%0d g%0d b%0d",
                     want.alpha, want.red, want.green, want.blue,
                     got.alpha, got.red, got.green, got.blue);
        end
      end
    end
  end

  // start held across a burst, dropped for a random gap after it
  task automatic send_texel(input logic [8:0] col, input logic [8:0] row,
                            input bit typed, input texel_t typed_texel);
    bit taken;
    start <= 1'b1;
    in_column <= col;
    in_row <= row;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      if (taken) texels_due.push_back(typed ? typed_texel : shade_texel(col, row));
      @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (texels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input csphr_pkg::reg_idx_t idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      csphr_pkg::REG_RADIUS:   radius_q = value[7:0];
      csphr_pkg::REG_TILT_COS: tilt_cos_q = value;
      csphr_pkg::REG_TILT_SIN: tilt_sin_q = value;
      csphr_pkg::REG_SPIN_COS: spin_cos_q = value;
      default:                 spin_sin_q = value;
    endcase
    @(posedge clk);
  endtask

  task automatic set_sphere(input logic [7:0] r, input logic signed [15:0] tc,
                            input logic signed [15:0] ts, input logic signed [15:0] sc,
                            input logic signed [15:0] ss);
    drain();
    write_reg(csphr_pkg::REG_RADIUS, {8'd0, r});
    write_reg(csphr_pkg::REG_TILT_COS, tc);
    write_reg(csphr_pkg::REG_TILT_SIN, ts);
    write_reg(csphr_pkg::REG_SPIN_COS, sc);
    write_reg(csphr_pkg::REG_SPIN_SIN, ss);
  endtask

  function automatic logic signed [15:0] rand_coef;
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_texels(input int n);
    int span;
    span = radius_q * 2;
    for (int i = 0; i < n; i++) begin
      if (span == 0 || $urandom_range(0, 7) == 0)
        send_texel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 1'b0, '0);
      else
        send_texel(9'($urandom_range(0, span - 1)), 9'($urandom_range(0, span - 1)),
                   1'b0, '0);
    end
  endtask

  stim_row_t directed[] = '{
    '{9'd0,   9'd0,   1'b1, texel_t'(32'h0)},
    '{9'd511, 9'd511, 1'b1, texel_t'(32'h0)},
    '{9'd240, 9'd0,   1'b1, texel_t'(32'h0)},
    '{9'd0,   9'd240, 1'b1, texel_t'(32'h0)},
    '{9'd239, 9'd239, 1'b1, texel_t'(32'h0)},
    '{9'd256, 9'd256, 1'b1, texel_t'(32'h0)},
    '{9'd384, 9'd1,   1'b1, texel_t'(32'h0)},
    '{9'd120, 9'd120, 1'b0, texel_t'(32'h0)},
    '{9'd0,   9'd120, 1'b0, texel_t'(32'h0)},
    '{9'd120, 9'd0,   1'b0, texel_t'(32'h0)},
    '{9'd239, 9'd120, 1'b0, texel_t'(32'h0)},
    '{9'd120, 9'd239, 1'b0, texel_t'(32'h0)},
    '{9'd1,   9'd120, 1'b0, texel_t'(32'h0)},
    '{9'd200, 9'd60,  1'b0, texel_t'(32'h0)},
    '{9'd35,  9'd170, 1'b0, texel_t'(32'h0)}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_texel(directed[i].col, directed[i].row, directed[i].typed, directed[i].texel);
    random_texels(200);

    // largest sphere, full-scale coefficients
    set_sphere(8'd255, 16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384);
    send_texel(9'd509, 9'd255, 1'b0, '0);
    send_texel(9'd510, 9'd255, 1'b1, texel_t'(32'h0));
    random_texels(200);

    // no tilt, no spin: rim top texel has zero direction
    set_sphere(8'd40, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
    send_texel(9'd40, 9'd0, 1'b0, '0);
    send_texel(9'd40, 9'd40, 1'b0, '0);
    random_texels(200);

    // half turn spin gives angle of exactly pi
    set_sphere(8'd20, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
    send_texel(9'd20, 9'd20, 1'b0, '0);
    random_texels(150);

    set_sphere(8'd1, -16'sd16384, 16'sd16384, 16'sd0, -16'sd16384);
    send_texel(9'd0, 9'd0, 1'b0, '0);
    send_texel(9'd1, 9'd1, 1'b0, '0);
    random_texels(40);

    set_sphere(8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_texel(9'd0, 9'd0, 1'b1, texel_t'(32'h0));
    random_texels(40);

    // unnormalised random rotations
    for (int p = 0; p < 4; p++) begin
      set_sphere(8'($urandom_range(2, 255)), rand_coef(), rand_coef(), rand_coef(),
                 rand_coef());
      random_texels(200);
    end

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/csphr_pkg.sv
hw/rtl/csphr_sqrt.sv
hw/rtl/csphr_div.sv
hw/rtl/checkered_sphere_rasterizer_top.sv
tb/checkered_sphere_rasterizer_top_tb.sv
